[rtl/core/mseu_pkg.sv]
// shared types, codes and defaults for the execute unit
package mseu_pkg;

   localparam int INDEX_WIDTH_DEF    = 16;
   localparam int REGISTER_COUNT_DEF = 32;

   localparam int REG_NUM_WIDTH = 5;
   localparam int DATA_WIDTH    = 32;
   localparam int IMM_WIDTH     = 16;
   localparam int CMD_WIDTH     = 4;
   localparam int EVENT_WIDTH   = 3;

   // operation codes
   localparam logic [CMD_WIDTH-1:0] CMD_ADD     = 4'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_SUB     = 4'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_SLT     = 4'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_MUL     = 4'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_BEQ     = 4'd4;
   localparam logic [CMD_WIDTH-1:0] CMD_BNE     = 4'd5;
   localparam logic [CMD_WIDTH-1:0] CMD_ADDI    = 4'd6;
   localparam logic [CMD_WIDTH-1:0] CMD_ORI     = 4'd7;
   localparam logic [CMD_WIDTH-1:0] CMD_LUI     = 4'd8;
   localparam logic [CMD_WIDTH-1:0] CMD_SYSCALL = 4'd9;

   // event codes
   localparam logic [EVENT_WIDTH-1:0] EV_NORMAL     = 3'd0;
   localparam logic [EVENT_WIDTH-1:0] EV_PRINT_INT  = 3'd1;
   localparam logic [EVENT_WIDTH-1:0] EV_PRINT_CHAR = 3'd2;
   localparam logic [EVENT_WIDTH-1:0] EV_EXIT       = 3'd3;
   localparam logic [EVENT_WIDTH-1:0] EV_BAD_SYS    = 3'd4;
   localparam logic [EVENT_WIDTH-1:0] EV_HALTED     = 3'd5;

   // syscall codes found in register 2
   localparam logic [DATA_WIDTH-1:0] SYS_PRINT_INT  = 32'd1;
   localparam logic [DATA_WIDTH-1:0] SYS_EXIT       = 32'd10;
   localparam logic [DATA_WIDTH-1:0] SYS_PRINT_CHAR = 32'd11;

   localparam logic [REG_NUM_WIDTH-1:0] REG_SYS_CODE = 5'd2;
   localparam logic [REG_NUM_WIDTH-1:0] REG_SYS_ARG  = 5'd4;

   localparam int                    LUI_SHIFT = 16;
   localparam logic [DATA_WIDTH-1:0] CHAR_MASK = 32'h0000_00FF;

   typedef struct packed {
      logic [EVENT_WIDTH-1:0]   event_kind;
      logic [DATA_WIDTH-1:0]    print_value;
      logic                     write_enable;
      logic [REG_NUM_WIDTH-1:0] write_reg;
      logic [DATA_WIDTH-1:0]    write_value;
      logic                     halt_set;
   } exec_res_type;

endpackage

[rtl/core/mseu_ram.sv]
// generic single write, single read ram with registered read data
module mseu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/mseu_exec.sv]
// combinational execute logic: alu, branch target, syscall decode
module mseu_exec #(
   parameter int INDEX_WIDTH    = mseu_pkg::INDEX_WIDTH_DEF,
   parameter int REGISTER_COUNT = mseu_pkg::REGISTER_COUNT_DEF
) (
   input  logic [mseu_pkg::CMD_WIDTH-1:0]     cmd,
   input  logic [mseu_pkg::REG_NUM_WIDTH-1:0] dest_reg,
   input  logic [mseu_pkg::REG_NUM_WIDTH-1:0] rt_reg,
   input  logic [mseu_pkg::IMM_WIDTH-1:0]     imm,
   input  logic [mseu_pkg::DATA_WIDTH-1:0]    opnd_a,
   input  logic [mseu_pkg::DATA_WIDTH-1:0]    opnd_b,
   input  logic [mseu_pkg::DATA_WIDTH-1:0]    sys_code,
   input  logic [mseu_pkg::DATA_WIDTH-1:0]    sys_arg,
   input  logic [INDEX_WIDTH-1:0]             index,
   input  logic                               halted,
   output mseu_pkg::exec_res_type             res,
   output logic [INDEX_WIDTH-1:0]             next_index
);

   logic [mseu_pkg::DATA_WIDTH-1:0]    imm_sx;
   logic [INDEX_WIDTH-1:0]             index_inc;
   logic [INDEX_WIDTH-1:0]             index_tgt;
   logic                               wr_raw;
   logic [mseu_pkg::REG_NUM_WIDTH-1:0] wr_reg_raw;
   logic [mseu_pkg::DATA_WIDTH-1:0]    wr_val_raw;
   logic                               wr_ok;

   assign imm_sx    = {{(mseu_pkg::DATA_WIDTH - mseu_pkg::IMM_WIDTH){imm[mseu_pkg::IMM_WIDTH-1]}},
                       imm};
   assign index_inc = index + INDEX_WIDTH'(1);
   assign index_tgt = index + imm_sx[INDEX_WIDTH-1:0];

   always_comb begin
      res          = '0;
      next_index   = index_inc;
      wr_raw       = 1'b0;
      wr_reg_raw   = dest_reg;
      wr_val_raw   = '0;
      if (halted) begin
         res.event_kind = mseu_pkg::EV_HALTED;
         next_index     = index;
      end else begin
         case (cmd)
            mseu_pkg::CMD_ADD: begin
               wr_raw     = 1'b1;
               wr_val_raw = opnd_a + opnd_b;
            end
            mseu_pkg::CMD_SUB: begin
               wr_raw     = 1'b1;
               wr_val_raw = opnd_a - opnd_b;
            end
            mseu_pkg::CMD_SLT: begin
               wr_raw     = 1'b1;
               wr_val_raw = {31'd0, $signed(opnd_a) < $signed(opnd_b)};
            end
            mseu_pkg::CMD_MUL: begin
               wr_raw     = 1'b1;
               wr_val_raw = opnd_a * opnd_b;
            end
            mseu_pkg::CMD_BEQ: begin
               if (opnd_a == opnd_b) begin
                  next_index = index_tgt;
               end
            end
            mseu_pkg::CMD_BNE: begin
               if (opnd_a != opnd_b) begin
                  next_index = index_tgt;
               end
            end
            mseu_pkg::CMD_ADDI: begin
               wr_raw     = 1'b1;
               wr_reg_raw = rt_reg;
               wr_val_raw = opnd_a + imm_sx;
            end
            mseu_pkg::CMD_ORI: begin
               wr_raw     = 1'b1;
               wr_reg_raw = rt_reg;
               wr_val_raw = opnd_a | imm_sx;
            end
            mseu_pkg::CMD_LUI: begin
               wr_raw     = 1'b1;
               wr_reg_raw = rt_reg;
               wr_val_raw = {16'd0, imm} << mseu_pkg::LUI_SHIFT;
            end
            mseu_pkg::CMD_SYSCALL: begin
               if (sys_code == mseu_pkg::SYS_PRINT_INT) begin
                  res.event_kind  = mseu_pkg::EV_PRINT_INT;
                  res.print_value = sys_arg;
               end else if (sys_code == mseu_pkg::SYS_PRINT_CHAR) begin
                  res.event_kind  = mseu_pkg::EV_PRINT_CHAR;
                  res.print_value = sys_arg & mseu_pkg::CHAR_MASK;
               end else if (sys_code == mseu_pkg::SYS_EXIT) begin
                  res.event_kind = mseu_pkg::EV_EXIT;
                  res.halt_set   = 1'b1;
                  next_index     = index;
               end else begin
                  res.event_kind = mseu_pkg::EV_BAD_SYS;
                  res.halt_set   = 1'b1;
                  next_index     = index;
               end
            end
            default: begin
            end
         endcase
      end
      // register zero and numbers past the file never take a write
      wr_ok = wr_raw && (wr_reg_raw != '0) &&
              ({1'b0, wr_reg_raw} < (mseu_pkg::REG_NUM_WIDTH + 1)'(REGISTER_COUNT));
      if (wr_ok) begin
         res.write_enable = 1'b1;
         res.write_reg    = wr_reg_raw;
         res.write_value  = wr_val_raw;
      end
   end

endmodule

[rtl/core/mips_subset_execute_unit_top.sv]
// top level of the decoded-instruction execute unit
// Executes one decoded instruction per word and returns one result word per
// instruction, at one word per cycle sustained while rsp_stall is low. A word
// is taken into an input register at the edge it is accepted; at that edge
// both source registers are read from two copies of the register file ram
// (read data registered), with a bypass for a write landing in the same
// cycle. Once the result register is free, the alu, branch target and
// syscall decode run in one pass and their outputs load the result register
// while the register file, the instruction index and the halted flag update
// at the same edge, so each word sees everything the word before it did.
// Register file entries read as zero until first written (one valid bit per
// entry, cleared at reset, no clearing pass); registers 2 and 4 are also
// kept in flip-flops for syscall decode. Once an exit or an unknown syscall
// halts the unit, every later word reports the ignored event and changes
// nothing until reset.
module mips_subset_execute_unit_top #(
   parameter int INDEX_WIDTH    = mseu_pkg::INDEX_WIDTH_DEF,
   parameter int REGISTER_COUNT = mseu_pkg::REGISTER_COUNT_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // instruction channel
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [mseu_pkg::CMD_WIDTH-1:0]            req_cmd,
   input  logic [mseu_pkg::REG_NUM_WIDTH-1:0]        req_dest_reg,
   input  logic [mseu_pkg::REG_NUM_WIDTH-1:0]        req_src_a_reg,
   input  logic [mseu_pkg::REG_NUM_WIDTH-1:0]        req_src_b_reg,
   input  logic signed [mseu_pkg::IMM_WIDTH-1:0]     req_immediate,
   // result channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [mseu_pkg::EVENT_WIDTH-1:0]          rsp_event_kind,
   output logic signed [mseu_pkg::DATA_WIDTH-1:0]    rsp_print_value,
   output logic                                      rsp_write_enable,
   output logic [mseu_pkg::REG_NUM_WIDTH-1:0]        rsp_write_reg,
   output logic signed [mseu_pkg::DATA_WIDTH-1:0]    rsp_write_value,
   output logic [INDEX_WIDTH-1:0]                    rsp_next_index
);

   localparam int AW = $clog2(REGISTER_COUNT);
   localparam int RW = mseu_pkg::REG_NUM_WIDTH;
   localparam int DW = mseu_pkg::DATA_WIDTH;

   // handshake
   logic in_vld_ff, in_vld_in;
   logic out_vld_ff, out_vld_in;
   logic req_acc;
   logic exec_go;

   // input stage
   logic [mseu_pkg::CMD_WIDTH-1:0] in_cmd_ff;
   logic [RW-1:0]                  in_dest_ff;
   logic [RW-1:0]                  in_rt_ff;
   logic [mseu_pkg::IMM_WIDTH-1:0] in_imm_ff;
   logic                           a_ok_ff, a_ok_in;
   logic                           b_ok_ff, b_ok_in;
   logic                           a_fwd_ff, a_fwd_in;
   logic                           b_fwd_ff, b_fwd_in;
   logic [DW-1:0]                  fwd_val_ff;

   // architectural state
   logic [REGISTER_COUNT-1:0] rf_vld_ff, rf_vld_in;
   logic [DW-1:0]             r2_ff, r2_in;
   logic [DW-1:0]             r4_ff, r4_in;
   logic [INDEX_WIDTH-1:0]    index_ff, index_in;
   logic                      halted_ff, halted_in;

   // result stage
   logic [mseu_pkg::EVENT_WIDTH-1:0] rsp_event_kind_ff;
   logic [DW-1:0]                    rsp_print_value_ff;
   logic                             rsp_write_enable_ff;
   logic [RW-1:0]                    rsp_write_reg_ff;
   logic [DW-1:0]                    rsp_write_value_ff;
   logic [INDEX_WIDTH-1:0]           rsp_next_index_ff;

   // datapath
   logic                   rng_a, rng_b;
   logic                   wb_en;
   logic [DW-1:0]          ram_a_q, ram_b_q;
   logic [DW-1:0]          opnd_a, opnd_b;
   mseu_pkg::exec_res_type exec_res;
   logic [INDEX_WIDTH-1:0] exec_next;

   // the input register moves on whenever the result register is free
   assign exec_go   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !exec_go;
   assign req_acc   = req_valid && !req_stall;
   assign wb_en     = exec_go && exec_res.write_enable;

   assign in_vld_in  = req_acc || (in_vld_ff && !exec_go);
   assign out_vld_in = exec_go || (out_vld_ff && rsp_stall);

   // source numbers that name a real, nonzero register
   assign rng_a = (req_src_a_reg != '0) && ({1'b0, req_src_a_reg} < (RW + 1)'(REGISTER_COUNT));
   assign rng_b = (req_src_b_reg != '0) && ({1'b0, req_src_b_reg} < (RW + 1)'(REGISTER_COUNT));

   // bypass for a write retiring at the same edge as the ram read
   assign a_fwd_in = wb_en && (exec_res.write_reg == req_src_a_reg);
   assign b_fwd_in = wb_en && (exec_res.write_reg == req_src_b_reg);
   assign a_ok_in  = rng_a && (rf_vld_ff[req_src_a_reg[AW-1:0]] || a_fwd_in);
   assign b_ok_in  = rng_b && (rf_vld_ff[req_src_b_reg[AW-1:0]] || b_fwd_in);

   // operand select: bypass, then ram if ever written, else zero
   assign opnd_a = a_fwd_ff ? fwd_val_ff : (a_ok_ff ? ram_a_q : '0);
   assign opnd_b = b_fwd_ff ? fwd_val_ff : (b_ok_ff ? ram_b_q : '0);

   // register file state updates
   always_comb begin
      rf_vld_in = rf_vld_ff;
      r2_in     = r2_ff;
      r4_in     = r4_ff;
      if (wb_en) begin
         rf_vld_in[exec_res.write_reg[AW-1:0]] = 1'b1;
         if (exec_res.write_reg == mseu_pkg::REG_SYS_CODE) begin
            r2_in = exec_res.write_value;
         end
         if (exec_res.write_reg == mseu_pkg::REG_SYS_ARG) begin
            r4_in = exec_res.write_value;
         end
      end
   end

   // index and halt follow the executed word (exec keeps them when halted)
   assign index_in  = exec_go ? exec_next : index_ff;
   assign halted_in = halted_ff || (exec_go && exec_res.halt_set);

   // two ram copies give two source reads per cycle
   mseu_ram #(
      .WIDTH (DW),
      .DEPTH (REGISTER_COUNT)
   ) u_rf_a (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (exec_res.write_reg[AW-1:0]),
      .wr_data (exec_res.write_value),
      .rd_en   (req_acc),
      .rd_addr (req_src_a_reg[AW-1:0]),
      .rd_data (ram_a_q)
   );

   mseu_ram #(
      .WIDTH (DW),
      .DEPTH (REGISTER_COUNT)
   ) u_rf_b (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (exec_res.write_reg[AW-1:0]),
      .wr_data (exec_res.write_value),
      .rd_en   (req_acc),
      .rd_addr (req_src_b_reg[AW-1:0]),
      .rd_data (ram_b_q)
   );

   mseu_exec #(
      .INDEX_WIDTH    (INDEX_WIDTH),
      .REGISTER_COUNT (REGISTER_COUNT)
   ) u_exec (
      .cmd        (in_cmd_ff),
      .dest_reg   (in_dest_ff),
      .rt_reg     (in_rt_ff),
      .imm        (in_imm_ff),
      .opnd_a     (opnd_a),
      .opnd_b     (opnd_b),
      .sys_code   (r2_ff),
      .sys_arg    (r4_ff),
      .index      (index_ff),
      .halted     (halted_ff),
      .res        (exec_res),
      .next_index (exec_next)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         rf_vld_ff  <= '0;
         r2_ff      <= '0;
         r4_ff      <= '0;
         index_ff   <= '0;
         halted_ff  <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         rf_vld_ff  <= rf_vld_in;
         r2_ff      <= r2_in;
         r4_ff      <= r4_in;
         index_ff   <= index_in;
         halted_ff  <= halted_in;
      end
   end

   // input stage payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_cmd_ff  <= req_cmd;
         in_dest_ff <= req_dest_reg;
         in_rt_ff   <= req_src_b_reg;
         in_imm_ff  <= req_immediate;
         a_ok_ff    <= a_ok_in;
         b_ok_ff    <= b_ok_in;
         a_fwd_ff   <= a_fwd_in;
         b_fwd_ff   <= b_fwd_in;
         fwd_val_ff <= exec_res.write_value;
      end
   end

   // result stage payload
   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_event_kind_ff   <= exec_res.event_kind;
         rsp_print_value_ff  <= exec_res.print_value;
         rsp_write_enable_ff <= exec_res.write_enable;
         rsp_write_reg_ff    <= exec_res.write_reg;
         rsp_write_value_ff  <= exec_res.write_value;
         rsp_next_index_ff   <= exec_next;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_event_kind   = rsp_event_kind_ff;
   assign rsp_print_value  = rsp_print_value_ff;
   assign rsp_write_enable = rsp_write_enable_ff;
   assign rsp_write_reg    = rsp_write_reg_ff;
   assign rsp_write_value  = rsp_write_value_ff;
   assign rsp_next_index   = rsp_next_index_ff;

   // checks

   // a halted unit only ever reports ignored words
   a_halted_ignores: assert property (@(posedge clock) disable iff (reset)
      halted_ff && exec_go |-> exec_res.event_kind == mseu_pkg::EV_HALTED)
      else $error("word executed while halted");

   // a word executed while halted leaves the index alone
   a_halted_index: assert property (@(posedge clock) disable iff (reset)
      halted_ff && exec_go |=> index_ff == $past(index_ff))
      else $error("index moved while halted");

   // input side only stalls on a full input register
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && out_vld_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   // register zero never becomes valid
   a_reg0_clear: assert property (@(posedge clock) disable iff (reset)
      wb_en |-> exec_res.write_reg != '0)
      else $error("write to register zero");

endmodule
